// ===== rtl/thw_pkg.sv =====
// Shared types and constants for the tracker module header walker.
// Depends on nothing; every other file in rtl/ but thw_in_reg refers to it by scoped names.
package thw_pkg;

  typedef enum logic [3:0] {
    PH_HEADER   = 4'd0,
    PH_SKIP     = 4'd1,
    PH_TRKSTART = 4'd2,
    PH_TRKREST  = 4'd3,
    PH_INSHEAD  = 4'd4,
    PH_INSBODY  = 4'd5,
    PH_TITLE    = 4'd6,
    PH_DONE     = 4'd7
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_MAGIC = 2'd1,
    ST_TRUNC = 2'd2,
    ST_LONG  = 2'd3
  } status_t;

  localparam logic [7:0] CHAR_T = 8'h54;
  localparam logic [7:0] CHAR_H = 8'h48;
  localparam logic [7:0] CHAR_X = 8'h58;
  localparam logic [7:0] CHAR_V = 8'h56;
  localparam logic [7:0] CHAR_L = 8'h4c;

  localparam logic [7:0] AHX_MAX_VER = 8'd3;   // version must be below this
  localparam logic [7:0] HVL_MAX_VER = 8'd2;
  localparam logic [7:0] HVL_SHORT_ENTRY = 8'h3f;

  localparam logic [6:0]  AHX_CHANNELS   = 7'd4;
  localparam logic [10:0] INS_HEAD_LEN   = 11'd22;
  localparam logic [10:0] AHX_ENTRY_REST = 11'd2;
  localparam logic [10:0] HVL_ENTRY_REST = 11'd4;
  localparam logic [10:0] AHX_INS_ENTRY  = 11'd4;
  localparam logic [10:0] HVL_INS_ENTRY  = 11'd5;

  typedef struct packed {
    status_t     status;
    logic        format_hvl;
    logic [6:0]  channels;
    logic [19:0] title_start;
    logic [19:0] title_length;
  } result_t;

  typedef struct packed {
    logic    emit;
    result_t res;
  } step_t;

  typedef struct packed {
    logic decided;
    logic in_title;
  } walk_stat_t;

endpackage

// ===== rtl/thw_in_reg.sv =====
// Input register of the header walker: holds one word and acts as the skid stage.
// Depends on thw_pkg only through the top level; no package items used here.
module thw_in_reg (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_data_byte,
  input  logic       in_last_byte,
  input  logic       go,
  output logic       s1_valid,
  output logic [7:0] s1_data_byte,
  output logic       s1_last_byte
);

  logic       valid_r;
  logic [7:0] data_r;
  logic       last_r;

  // held word can only leave when the walker may advance
  assign in_stall = valid_r & ~go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (!in_stall) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      data_r <= in_data_byte;
      last_r <= in_last_byte;
    end
  end

  assign s1_valid     = valid_r;
  assign s1_data_byte = data_r;
  assign s1_last_byte = last_r;

endmodule

// ===== rtl/thw_walker.sv =====
// Header walker state and per-byte step logic: magic check, header capture,
// list skip, track and instrument walk, title scan. Depends on thw_pkg.
module thw_walker #(
  parameter int OFFSET_BITS = 20
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               advance,
  input  logic [7:0]         data_byte,
  input  logic               last_byte,
  output thw_pkg::step_t     step_o,
  output thw_pkg::walk_stat_t stat_o
);

  localparam int PW = OFFSET_BITS + 1;

  thw_pkg::phase_t phase_r, phase_nxt;
  logic [PW-1:0]   pos_r, pos_nxt;
  logic            hvl_r, hvl_nxt;
  logic [11:0]     pos_count_r, pos_count_nxt;
  logic [7:0]      trk_len_r, trk_len_nxt;
  logic [7:0]      trk_count_r, trk_count_nxt;
  logic [7:0]      ins_count_r, ins_count_nxt;
  logic [7:0]      sub_count_r, sub_count_nxt;
  logic            trk0_r, trk0_nxt;
  logic [6:0]      chan_r, chan_nxt;
  logic [20:0]     skip_r, skip_nxt;
  logic [8:0]      trk_left_r, trk_left_nxt;
  logic [7:0]      ent_left_r, ent_left_nxt;
  logic [7:0]      ins_left_r, ins_left_nxt;
  logic [10:0]     chunk_r, chunk_nxt;
  logic [19:0]     title_off_r, title_off_nxt;
  logic [19:0]     title_cnt_r, title_cnt_nxt;
  logic            decided_r, decided_nxt;

  logic [18:0]     pos_by_chan;
  logic [32:0]     pos_wide;

  assign pos_by_chan = 19'(pos_count_r) * 19'(chan_r);

  always_comb begin
    logic            emit;
    thw_pkg::status_t st;
    logic [PW-1:0]   hdr_last;

    phase_nxt     = phase_r;
    pos_nxt       = pos_r;
    hvl_nxt       = hvl_r;
    pos_count_nxt = pos_count_r;
    trk_len_nxt   = trk_len_r;
    trk_count_nxt = trk_count_r;
    ins_count_nxt = ins_count_r;
    sub_count_nxt = sub_count_r;
    trk0_nxt      = trk0_r;
    chan_nxt      = chan_r;
    skip_nxt      = skip_r;
    trk_left_nxt  = trk_left_r;
    ent_left_nxt  = ent_left_r;
    ins_left_nxt  = ins_left_r;
    chunk_nxt     = chunk_r;
    title_off_nxt = title_off_r;
    title_cnt_nxt = title_cnt_r;
    decided_nxt   = decided_r;
    emit          = 1'b0;
    st            = thw_pkg::ST_OK;
    hdr_last      = hvl_r ? PW'(15) : PW'(13);
    pos_wide      = '0;

    if (!decided_r) begin
      if (pos_r[OFFSET_BITS]) begin
        emit = 1'b1;
        st   = thw_pkg::ST_LONG;
      end else begin
        case (phase_r)
          thw_pkg::PH_HEADER: begin
            if (pos_r == PW'(0)) begin
              if (data_byte == thw_pkg::CHAR_T) begin
                hvl_nxt = 1'b0;
              end else if (data_byte == thw_pkg::CHAR_H) begin
                hvl_nxt = 1'b1;
              end else begin
                emit = 1'b1;
                st   = thw_pkg::ST_MAGIC;
              end
            end else if (pos_r == PW'(1)) begin
              if (data_byte != (hvl_r ? thw_pkg::CHAR_V : thw_pkg::CHAR_H)) begin
                emit = 1'b1;
                st   = thw_pkg::ST_MAGIC;
              end
            end else if (pos_r == PW'(2)) begin
              if (data_byte != (hvl_r ? thw_pkg::CHAR_L : thw_pkg::CHAR_X)) begin
                emit = 1'b1;
                st   = thw_pkg::ST_MAGIC;
              end
            end else if (pos_r == PW'(3)) begin
              if (data_byte >= (hvl_r ? thw_pkg::HVL_MAX_VER : thw_pkg::AHX_MAX_VER)) begin
                emit = 1'b1;
                st   = thw_pkg::ST_MAGIC;
              end
            end else if (pos_r == PW'(6)) begin
              trk0_nxt      = ~data_byte[7];
              pos_count_nxt = {data_byte[3:0], 8'h00};
            end else if (pos_r == PW'(7)) begin
              pos_count_nxt = {pos_count_r[11:8], data_byte};
            end else if (pos_r == PW'(8)) begin
              if (hvl_r) begin
                chan_nxt = 7'({1'b0, data_byte[7:2]}) + thw_pkg::AHX_CHANNELS;
              end
            end else if (pos_r == PW'(10)) begin
              trk_len_nxt = data_byte;
            end else if (pos_r == PW'(11)) begin
              trk_count_nxt = data_byte;
            end else if (pos_r == PW'(12)) begin
              ins_count_nxt = data_byte;
            end else if (pos_r == PW'(13)) begin
              sub_count_nxt = data_byte;
            end
            if (!emit && pos_r == hdr_last) begin
              // subsongs are 2 bytes, positions 2 bytes per channel
              skip_nxt  = 21'({sub_count_nxt, 1'b0}) + 21'({pos_by_chan, 1'b0});
              phase_nxt = thw_pkg::PH_SKIP;
            end
          end
          thw_pkg::PH_SKIP: begin
            skip_nxt = skip_r - 21'd1;
          end
          thw_pkg::PH_TRKSTART: begin
            if (hvl_r && data_byte == thw_pkg::HVL_SHORT_ENTRY) begin
              ent_left_nxt = ent_left_r - 8'd1;
              if (ent_left_nxt == 8'd0) begin
                trk_left_nxt = trk_left_r - 9'd1;
                ent_left_nxt = trk_len_r;
              end
            end else begin
              chunk_nxt = hvl_r ? thw_pkg::HVL_ENTRY_REST : thw_pkg::AHX_ENTRY_REST;
              phase_nxt = thw_pkg::PH_TRKREST;
            end
          end
          thw_pkg::PH_TRKREST: begin
            chunk_nxt = chunk_r - 11'd1;
            if (chunk_nxt == 11'd0) begin
              phase_nxt    = thw_pkg::PH_TRKSTART;
              ent_left_nxt = ent_left_r - 8'd1;
              if (ent_left_nxt == 8'd0) begin
                trk_left_nxt = trk_left_r - 9'd1;
                ent_left_nxt = trk_len_r;
              end
            end
          end
          thw_pkg::PH_INSHEAD: begin
            chunk_nxt = chunk_r - 11'd1;
            if (chunk_nxt == 11'd0) begin
              // last header byte holds the entry count
              chunk_nxt = 11'(data_byte) *
                          (hvl_r ? thw_pkg::HVL_INS_ENTRY : thw_pkg::AHX_INS_ENTRY);
              phase_nxt = thw_pkg::PH_INSBODY;
            end
          end
          thw_pkg::PH_INSBODY: begin
            chunk_nxt = chunk_r - 11'd1;
          end
          thw_pkg::PH_TITLE: begin
            if (data_byte == 8'h00) begin
              emit = 1'b1;
              st   = thw_pkg::ST_OK;
            end else begin
              title_cnt_nxt = title_cnt_r + 20'd1;
            end
          end
          default: begin
          end
        endcase

        pos_nxt = pos_r + PW'(1);

        if (!emit) begin
          // fall through empty sections; order follows the file layout
          if (phase_nxt == thw_pkg::PH_SKIP && skip_nxt == 21'd0) begin
            phase_nxt    = thw_pkg::PH_TRKSTART;
            trk_left_nxt = {1'b0, trk_count_nxt} + 9'(trk0_nxt);
            ent_left_nxt = trk_len_nxt;
          end
          if (phase_nxt == thw_pkg::PH_TRKSTART &&
              (trk_left_nxt == 9'd0 || trk_len_nxt == 8'd0)) begin
            phase_nxt    = thw_pkg::PH_INSHEAD;
            ins_left_nxt = ins_count_nxt;
            chunk_nxt    = thw_pkg::INS_HEAD_LEN;
          end
          if (phase_nxt == thw_pkg::PH_INSBODY && chunk_nxt == 11'd0) begin
            ins_left_nxt = ins_left_nxt - 8'd1;
            phase_nxt    = thw_pkg::PH_INSHEAD;
            chunk_nxt    = thw_pkg::INS_HEAD_LEN;
          end
          if (phase_nxt == thw_pkg::PH_INSHEAD && ins_left_nxt == 8'd0) begin
            phase_nxt     = thw_pkg::PH_TITLE;
            pos_wide      = 33'(pos_nxt);
            title_off_nxt = pos_wide[19:0];
            title_cnt_nxt = 20'd0;
          end
        end
      end

      if (!emit && last_byte) begin
        emit = 1'b1;
        st   = thw_pkg::ST_TRUNC;
      end
      if (emit) begin
        decided_nxt = 1'b1;
        phase_nxt   = thw_pkg::PH_DONE;
      end
    end

    step_o.emit           = emit;
    step_o.res.status     = st;
    step_o.res.format_hvl = (st == thw_pkg::ST_MAGIC) ? 1'b0 : hvl_nxt;
    step_o.res.channels   = (st == thw_pkg::ST_MAGIC) ? thw_pkg::AHX_CHANNELS : chan_nxt;
    step_o.res.title_start  = (st == thw_pkg::ST_OK) ? title_off_nxt : 20'd0;
    step_o.res.title_length = (st == thw_pkg::ST_OK) ? title_cnt_nxt : 20'd0;
  end

  assign stat_o.decided  = decided_r;
  assign stat_o.in_title = (phase_r == thw_pkg::PH_TITLE);

  // the final word of a file rearms everything, as at reset
  always_ff @(posedge clk) begin
    if (!rst_n || (advance && last_byte)) begin
      phase_r     <= thw_pkg::PH_HEADER;
      pos_r       <= '0;
      hvl_r       <= 1'b0;
      pos_count_r <= '0;
      trk_len_r   <= '0;
      trk_count_r <= '0;
      ins_count_r <= '0;
      sub_count_r <= '0;
      trk0_r      <= 1'b0;
      chan_r      <= thw_pkg::AHX_CHANNELS;
      skip_r      <= '0;
      trk_left_r  <= '0;
      ent_left_r  <= '0;
      ins_left_r  <= '0;
      chunk_r     <= '0;
      title_off_r <= '0;
      title_cnt_r <= '0;
      decided_r   <= 1'b0;
    end else if (advance) begin
      phase_r     <= phase_nxt;
      pos_r       <= pos_nxt;
      hvl_r       <= hvl_nxt;
      pos_count_r <= pos_count_nxt;
      trk_len_r   <= trk_len_nxt;
      trk_count_r <= trk_count_nxt;
      ins_count_r <= ins_count_nxt;
      sub_count_r <= sub_count_nxt;
      trk0_r      <= trk0_nxt;
      chan_r      <= chan_nxt;
      skip_r      <= skip_nxt;
      trk_left_r  <= trk_left_nxt;
      ent_left_r  <= ent_left_nxt;
      ins_left_r  <= ins_left_nxt;
      chunk_r     <= chunk_nxt;
      title_off_r <= title_off_nxt;
      title_cnt_r <= title_cnt_nxt;
      decided_r   <= decided_nxt;
    end
  end

endmodule

// ===== rtl/thw_out_reg.sv =====
// Result register of the header walker: one result word held until taken.
// Depends on thw_pkg for the result type.
module thw_out_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  thw_pkg::result_t  res_i,
  output logic              out_valid,
  input  logic              out_stall,
  output thw_pkg::result_t  res_o
);

  logic             valid_r, valid_nxt;
  thw_pkg::result_t res_r;

  always_comb begin
    if (load) begin
      valid_nxt = 1'b1;
    end else if (valid_r && !out_stall) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_i;
    end
  end

  assign out_valid = valid_r;
  assign res_o     = res_r;

endmodule

// ===== rtl/tracker_module_header_walker_core.sv =====
// Top level of the tracker module header walker: input register, walker, result register.
// Depends on thw_pkg, thw_in_reg, thw_walker and thw_out_reg.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+-----------------------------------------
//  in_     | in        | in_valid / in_stall | in_data_byte[7:0], in_last_byte
//  out_    | out       | out_valid/out_stall | out_status[1:0], out_format_hvl,
//          |           |                     | out_channels[6:0], out_title_start[19:0],
//          |           |                     | out_title_length[19:0]
//
// One word per cycle sustained unless a result-producing word is held; each word is
// registered in the input register on acceptance and stepped through the walker logic,
// and the result register loads, raising out_valid, when the deciding word advances.
// Reset is synchronous (rst_n low); no clearing pass is needed.
// A word that produces no result keeps flowing while a result waits at the output;
// a result-producing word is held in the input register, with in_stall high, until
// the waiting result is taken.
module tracker_module_header_walker_core #(
  parameter int OFFSET_BITS = 20
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic        out_format_hvl,
  output logic [6:0]  out_channels,
  output logic [19:0] out_title_start,
  output logic [19:0] out_title_length
);

  logic                s1_valid;
  logic [7:0]          s1_data_byte;
  logic                s1_last_byte;
  logic                s1_go;
  logic                advance;
  logic                out_load;
  thw_pkg::step_t      step;
  thw_pkg::walk_stat_t stat;
  thw_pkg::result_t    res;

  // a word that would emit must wait while the result register is held
  assign s1_go    = ~(out_valid & out_stall & step.emit);
  assign advance  = s1_valid & s1_go;
  assign out_load = advance & step.emit;

  thw_in_reg u_in (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data_byte (in_data_byte),
    .in_last_byte (in_last_byte),
    .go           (s1_go),
    .s1_valid     (s1_valid),
    .s1_data_byte (s1_data_byte),
    .s1_last_byte (s1_last_byte)
  );

  thw_walker #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_walker (
    .clk       (clk),
    .rst_n     (rst_n),
    .advance   (advance),
    .data_byte (s1_data_byte),
    .last_byte (s1_last_byte),
    .step_o    (step),
    .stat_o    (stat)
  );

  thw_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (out_load),
    .res_i     (step.res),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .res_o     (res)
  );

  assign out_status       = res.status;
  assign out_format_hvl   = res.format_hvl;
  assign out_channels     = res.channels;
  assign out_title_start  = res.title_start;
  assign out_title_length = res.title_length;

  // once a file is decided, nothing more comes out until it ends
  a_no_second_result: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid && stat.decided) |-> !step.emit)
    else $error("second result for one file");

  a_ok_from_title: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid && step.emit && step.res.status == thw_pkg::ST_OK) |-> stat.in_title)
    else $error("ok status outside the title scan");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |-> !out_load)
    else $error("held result overwritten");

  a_result_shown: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> out_valid)
    else $error("loaded result not presented");

endmodule
